[rtl/bsr_pkg.sv]
// ============================================================================
// bsr_pkg
// Shared widths, command and result codes and the result type of the
// bounded byte stack with rotate.
// ============================================================================
`default_nettype none

package bsr_pkg;

   // Field widths of the request, the result and the capacity register.
   localparam int ModeW  = 3;
   localparam int DataW  = 8;
   localparam int CountW = 6;
   localparam int KindW  = 2;
   localparam int CapW   = 6;

   // Configuration port geometry.
   localparam int PAddrW = 3;
   localparam int PDataW = 32;

   // Default store depth and capacity after reset.
   localparam int DepthDefault = 32;
   localparam logic [CapW-1:0] CapReset = 6'd32;

   // A print emits at most this many entries.
   localparam int MaxResults = 32;

   // Command codes.
   localparam logic [ModeW-1:0] ModePush  = 3'd0;
   localparam logic [ModeW-1:0] ModePop   = 3'd1;
   localparam logic [ModeW-1:0] ModePeek  = 3'd2;
   localparam logic [ModeW-1:0] ModeDup   = 3'd3;
   localparam logic [ModeW-1:0] ModeRotUp = 3'd4;
   localparam logic [ModeW-1:0] ModeRotDn = 3'd5;
   localparam logic [ModeW-1:0] ModePrint = 3'd6;

   // Result kinds.
   localparam logic [KindW-1:0] KindByte  = 2'd0;
   localparam logic [KindW-1:0] KindFull  = 2'd1;
   localparam logic [KindW-1:0] KindEmpty = 2'd2;

   // One result item.
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [DataW-1:0] value;
      logic             last;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/bsr_if.sv]
// ============================================================================
// bsr_if
// Valid/ready channels for stack requests and stack results.
// ============================================================================
`default_nettype none

interface bsr_req_if;
   import bsr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ModeW-1:0]  mode;
   logic [DataW-1:0]  data;
   logic [CountW-1:0] count;

   modport source (output valid, output mode, output data, output count, input ready);
   modport sink   (input valid, input mode, input data, input count, output ready);
endinterface

interface bsr_rsp_if;
   import bsr_pkg::*;

   logic             valid;
   logic             ready;
   logic [KindW-1:0] kind;
   logic [DataW-1:0] value;
   logic             last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

[rtl/bsr_mem.sv]
// ============================================================================
// bsr_mem
// Entry store of the stack: one write port and one read port, with the read
// data registered.
// ============================================================================
`default_nettype none

module bsr_mem #(
   parameter int DEPTH = bsr_pkg::DepthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       mem_we,
   input  wire logic [$clog2(DEPTH)-1:0]   mem_waddr,
   input  wire logic [bsr_pkg::DataW-1:0]  mem_wdata,
   input  wire logic [$clog2(DEPTH)-1:0]   mem_raddr,
   output logic      [bsr_pkg::DataW-1:0]  mem_rdata
);
   import bsr_pkg::*;

   logic [DataW-1:0] store_mem [DEPTH];
   logic [DataW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Read port, read every cycle; a write to the same entry returns old data.
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[mem_raddr];
   end

   assign mem_rdata = rd_data_ff;

endmodule

`default_nettype wire

[rtl/bsr_csr.sv]
// ============================================================================
// bsr_csr
// APB-style register port holding the capacity register, and the clamped
// capacity that the sequencer compares against.
// ============================================================================
`default_nettype none

module bsr_csr #(
   parameter int DEPTH = bsr_pkg::DepthDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [bsr_pkg::PAddrW-1:0]   paddr,
   input  wire logic [bsr_pkg::PDataW-1:0]   pwdata,
   output logic      [bsr_pkg::PDataW-1:0]   prdata,
   output logic                              pready,
   output logic      [$clog2(DEPTH+1)-1:0]   cap_eff
);
   import bsr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CapW-1:0] capacity_ff;
   logic [CapW-1:0] capacity_in;
   logic            cap_hit;

   // The capacity register sits at byte address zero.
   assign cap_hit = (paddr[PAddrW-1] == 1'b0);
   assign pready  = 1'b1;

   // Register write in the access phase.
   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && cap_hit) begin
         capacity_in = pwdata[CapW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapReset;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Read data.
   assign prdata = cap_hit ? PDataW'(capacity_ff) : '0;

   // A capacity of zero acts as one, and one above the depth as the depth.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CW'(1);
      end else if (32'(capacity_ff) > DEPTH) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = CW'(capacity_ff);
      end
   end

endmodule

`default_nettype wire

[rtl/bsr_ctrl.sv]
// ============================================================================
// bsr_ctrl
// Command sequencer of the stack: keeps the fill count, drives the entry
// store through its read and write ports, and holds the result output register.
// ============================================================================
`default_nettype none

module bsr_ctrl #(
   parameter int DEPTH = bsr_pkg::DepthDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bsr_req_if.sink                          req_if,
   bsr_rsp_if.source                        rsp_if,
   input  wire logic [$clog2(DEPTH+1)-1:0]  cap_eff,
   output logic                             mem_we,
   output logic      [$clog2(DEPTH)-1:0]    mem_waddr,
   output logic      [bsr_pkg::DataW-1:0]   mem_wdata,
   output logic      [$clog2(DEPTH)-1:0]    mem_raddr,
   input  wire logic [bsr_pkg::DataW-1:0]   mem_rdata
);
   import bsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_OUT  = 8'b0000_0010,
      ST_DUPW = 8'b0000_0100,
      ST_ROTT = 8'b0000_1000,
      ST_ROTM = 8'b0001_0000,
      ST_ROTE = 8'b0010_0000,
      ST_PRT  = 8'b0100_0000,
      ST_STAT = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     fc_ff, fc_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [DataW-1:0]  tmp_ff, tmp_in;
   logic              up_ff, up_in;
   logic [KindW-1:0]  kind_ff, kind_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_pay_ff, rsp_pay_in;

   logic              accept;
   logic              out_free;
   logic              emit;
   rsp_payload_type   emit_pay;
   logic              full;
   logic              empty;
   logic              rot_ok;
   logic [AW-1:0]     top_addr;
   logic [AW-1:0]     base_addr;
   logic [AW-1:0]     ptr_step;
   logic [AW-1:0]     ptr_step2;
   logic [CountW-1:0] print_k;

   // Handshake and output register availability.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Stack status and addresses derived from the fill count.
   assign full      = (fc_ff >= cap_eff);
   assign empty     = (fc_ff == '0);
   assign top_addr  = AW'(fc_ff - CW'(1));
   assign base_addr = AW'(32'(fc_ff) - 32'(req_if.count));
   assign rot_ok    = (req_if.count >= CountW'(2)) && (32'(req_if.count) <= 32'(fc_ff));
   assign print_k   = (32'(fc_ff) > MaxResults) ? CountW'(MaxResults) : CountW'(fc_ff);

   // Rotate walks down the stack for rotate up and up the stack for rotate down.
   assign ptr_step  = up_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
   assign ptr_step2 = up_ff ? (ptr_step - AW'(1)) : (ptr_step + AW'(1));

   // Sequencer. Every cycle issues at most one read and one write, and no read
   // whose data is used targets the entry written in the same cycle, so no forwarding
   // is needed: a moved byte is read two entries ahead of the write.
   always_comb begin
      state_in  = state_ff;
      fc_in     = fc_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      tmp_in    = tmp_ff;
      up_in     = up_ff;
      kind_in   = kind_ff;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = tmp_ff;
      mem_raddr = ptr_ff;
      emit      = 1'b0;
      emit_pay  = '{kind: KindByte, value: mem_rdata, last: 1'b1};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.mode)
                  ModePush: begin
                     if (full) begin
                        kind_in  = KindFull;
                        state_in = ST_STAT;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(fc_ff);
                        mem_wdata = req_if.data;
                        fc_in     = fc_ff + CW'(1);
                     end
                  end
                  ModePop, ModePeek: begin
                     if (empty) begin
                        kind_in  = KindEmpty;
                        state_in = ST_STAT;
                     end else begin
                        mem_raddr = top_addr;
                        ptr_in    = top_addr;
                        state_in  = ST_OUT;
                        if (req_if.mode == ModePop) begin
                           fc_in = fc_ff - CW'(1);
                        end
                     end
                  end
                  ModeDup: begin
                     if (empty) begin
                        kind_in  = KindEmpty;
                        state_in = ST_STAT;
                     end else if (full) begin
                        kind_in  = KindFull;
                        state_in = ST_STAT;
                     end else begin
                        mem_raddr = top_addr;
                        ptr_in    = top_addr;
                        fc_in     = fc_ff + CW'(1);
                        state_in  = ST_DUPW;
                     end
                  end
                  ModeRotUp: begin
                     if (rot_ok) begin
                        mem_raddr = top_addr;
                        ptr_in    = top_addr;
                        up_in     = 1'b1;
                        cnt_in    = req_if.count - CountW'(1);
                        state_in  = ST_ROTT;
                     end
                  end
                  ModeRotDn: begin
                     if (rot_ok) begin
                        mem_raddr = base_addr;
                        ptr_in    = base_addr;
                        up_in     = 1'b0;
                        cnt_in    = req_if.count - CountW'(1);
                        state_in  = ST_ROTT;
                     end
                  end
                  ModePrint: begin
                     if (!empty) begin
                        mem_raddr = top_addr;
                        ptr_in    = top_addr;
                        cnt_in    = print_k;
                        state_in  = ST_PRT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Pop or peek: the top byte is on the read port.
         ST_OUT: begin
            mem_raddr = ptr_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // Duplicate: write the top byte one entry higher.
         ST_DUPW: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + AW'(1);
            mem_wdata = mem_rdata;
            state_in  = ST_IDLE;
         end

         // Rotate: hold the byte that wraps around, fetch the first to move.
         ST_ROTT: begin
            tmp_in    = mem_rdata;
            mem_raddr = ptr_step;
            state_in  = ST_ROTM;
         end

         // Rotate: move one byte per cycle toward the starting end.
         ST_ROTM: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = mem_rdata;
            mem_raddr = ptr_step2;
            ptr_in    = ptr_step;
            cnt_in    = cnt_ff - CountW'(1);
            if (cnt_ff == CountW'(1)) begin
               state_in = ST_ROTE;
            end
         end

         // Rotate: the held byte lands at the far end.
         ST_ROTE: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = tmp_ff;
            state_in  = ST_IDLE;
         end

         // Print: one entry per cycle from the top; re-read while stalled.
         ST_PRT: begin
            mem_raddr = ptr_ff;
            if (out_free) begin
               emit          = 1'b1;
               emit_pay.last = (cnt_ff == CountW'(1));
               if (cnt_ff == CountW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in    = ptr_ff - AW'(1);
                  cnt_in    = cnt_ff - CountW'(1);
                  mem_raddr = ptr_ff - AW'(1);
               end
            end
         end

         // Full or empty status.
         ST_STAT: begin
            if (out_free) begin
               emit     = 1'b1;
               emit_pay = '{kind: kind_ff, value: '0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result output register.
   always_comb begin
      rsp_pay_in = rsp_pay_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = emit_pay;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind  = rsp_pay_ff.kind;
   assign rsp_if.value = rsp_pay_ff.value;
   assign rsp_if.last  = rsp_pay_ff.last;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      cnt_ff     <= cnt_in;
      tmp_ff     <= tmp_in;
      up_ff      <= up_in;
      kind_ff    <= kind_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   // The fill count never passes the store depth.
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fc_ff) <= DEPTH)
      else $error("fill count exceeds store depth");

   // Only a newly taken request changes the fill count.
   a_fc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> (fc_ff == $past(fc_ff)))
      else $error("fill count changed while a command was in progress");

   // A result is loaded only when the output register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrote a waiting result");

   // A write and a read of the same entry never coincide while a rotate moves bytes.
   a_rot_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTM) |-> (mem_waddr != mem_raddr || DEPTH <= 2))
      else $error("rotate read and write hit the same entry");

endmodule

`default_nettype wire

[rtl/byte_stack_with_rotate_top.sv]
// ============================================================================
// byte_stack_with_rotate_top
// Bounded byte stack with push, pop, peek, duplicate, rotate and print.
// ============================================================================
// The stack holds its bytes in a single-port-write, single-port-read memory
// of DEPTH entries with registered read data, and one request is worked at
// a time. A push writes on acceptance; pop and peek read the top entry and
// emit it; duplicate reads it and writes it one entry higher; a rotate
// turns the top n entries by one place, or leaves the stack as it is if n
// is below 2 or above the fill count; a print of a stack of f entries emits
// min(f, 32) results from the top, one result per cycle while the result
// side keeps up. Results wait in an output register, so a request that
// makes no result (push, rotate) is taken while an earlier result is still
// waiting. The memory needs no clearing after reset: no entry is read before
// written. The capacity register lies at byte address 0 and resets to 32.
// ============================================================================
`default_nettype none

module byte_stack_with_rotate_top #(
   parameter int DEPTH = bsr_pkg::DepthDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bsr_req_if.sink                          req_if,
   bsr_rsp_if.source                        rsp_if,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [bsr_pkg::PAddrW-1:0]  paddr,
   input  wire logic [bsr_pkg::PDataW-1:0]  pwdata,
   output logic      [bsr_pkg::PDataW-1:0]  prdata,
   output logic                             pready
);
   import bsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]    cap_eff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [DataW-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [DataW-1:0] mem_rdata;

   // Capacity register.
   bsr_csr #(.DEPTH(DEPTH)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   // Command sequencer and result register.
   bsr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .cap_eff   (cap_eff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Entry store.
   bsr_mem #(.DEPTH(DEPTH)) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire
